/* hdl/crt_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// crt_pkg
// Shared types and constants of the congruence merge block.
// ============================================================================
package crt_pkg;

    localparam int FIELD_W   = 48;
    localparam int WIDTH_DEF = 48;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_RED,
        S_GTEST,
        S_GQ,
        S_GQM,
        S_GMM,
        S_RRM,
        S_DIFF,
        S_MP,
        S_SMP,
        S_T,
        S_LIM,
        S_TL,
        S_LM,
        S_OUT
    } t_state;

    // Datapath commands, one per controller step
    typedef enum logic [4:0] {
        C_NOP,
        C_ACCEPT,
        C_START_SET,
        C_RED_DONE,
        C_GCD_DIV,
        C_GQ_DONE,
        C_GQM_DONE,
        C_GMM_DONE,
        C_RRM_START,
        C_RRM_DONE,
        C_DIFF_FAIL,
        C_DIFF_OK,
        C_MP_DONE,
        C_SMP_DONE,
        C_T_DONE,
        C_LIM_OVF,
        C_LIM_OK,
        C_TL_DONE,
        C_LM_DONE,
        C_OUT
    } t_cmd;

    // Iterative arithmetic unit operations
    typedef enum logic [1:0] {
        E_DIV,
        E_MODMUL,
        E_MUL
    } t_eng_op;

    typedef struct packed {
        logic eng_done;
        logic start_flag;
        logic stop;
        logic r1_zero;
        logic rem_nz;
        logic lim_over;
        logic out_busy;
    } t_status;

endpackage

/* hdl/crt_if.sv */
`timescale 1ns / 1ps
// ============================================================================
// crt_in_if / crt_out_if
// Valid/ready channels carrying congruences in and merged results out.
// ============================================================================
interface crt_in_if
    import crt_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] residue;
    logic [FIELD_W-1:0] modulus;
    logic               start_req;

    modport source (output valid, output residue, output modulus, output start_req,
                    input ready);
    modport sink   (input valid, input residue, input modulus, input start_req,
                    output ready);
endinterface

interface crt_out_if
    import crt_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] solution;
    logic [FIELD_W-1:0] combined_modulus;
    logic               consistent;
    logic               overflow;

    modport source (output valid, output solution, output combined_modulus,
                    output consistent, output overflow, input ready);
    modport sink   (input valid, input solution, input combined_modulus,
                    input consistent, input overflow, output ready);
endinterface

/* hdl/crt_engine.sv */
`timescale 1ns / 1ps
// ============================================================================
// crt_engine
// Iterative arithmetic unit: restoring divide, add-and-double modular
// multiply and shift-add multiply, one bit per cycle.
// ============================================================================
module crt_engine
    import crt_pkg::*;
#(
    parameter int VW = 48
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  t_eng_op       i_op,
    input  logic [VW-1:0] i_a,
    input  logic [VW-1:0] i_b,
    input  logic [VW-1:0] i_m,
    output logic          o_done,
    output logic [VW-1:0] o_quo,
    output logic [VW-1:0] o_rem
);

    localparam int CW = $clog2(VW + 1);

    t_eng_op       r_op;
    logic [VW-1:0] r_a, r_b, r_m, r_acc;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done;

    logic [VW:0]   w_sh, w_sum, w_dbl, w_mm;

    always_comb begin
        w_sh  = {r_acc, r_a[VW-1]};
        w_sum = {1'b0, r_acc} + {1'b0, r_a};
        w_dbl = {r_a, 1'b0};
        w_mm  = {1'b0, r_m};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(VW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_op  <= i_op;
            r_a   <= i_a;
            r_b   <= i_b;
            r_m   <= i_m;
            r_acc <= '0;
        end else if (r_busy) begin
            case (r_op)
                E_DIV: begin
                    if (w_sh >= w_mm) begin
                        r_acc <= VW'(w_sh - w_mm);
                        r_a   <= {r_a[VW-2:0], 1'b1};
                    end else begin
                        r_acc <= VW'(w_sh);
                        r_a   <= {r_a[VW-2:0], 1'b0};
                    end
                end
                E_MODMUL: begin
                    if (r_b[0]) begin
                        r_acc <= (w_sum >= w_mm) ? VW'(w_sum - w_mm) : VW'(w_sum);
                    end
                    r_a <= (w_dbl >= w_mm) ? VW'(w_dbl - w_mm) : VW'(w_dbl);
                    r_b <= r_b >> 1;
                end
                E_MUL: begin
                    if (r_b[0]) begin
                        r_acc <= r_acc + r_a;
                    end
                    r_a <= r_a << 1;
                    r_b <= r_b >> 1;
                end
                default: begin
                    r_acc <= r_acc;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_a;
    assign o_rem  = r_acc;

endmodule

/* hdl/crt_dpath.sv */
`timescale 1ns / 1ps
// ============================================================================
// crt_dpath
// Datapath: merged system state, extended Euclid registers, output register
// and the shared arithmetic unit, all driven by controller commands.
// ============================================================================
module crt_dpath
    import crt_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cmd            i_cmd,
    output t_status         o_status,
    crt_in_if.sink          i_in,
    crt_out_if.source       o_out
);

    localparam int VW = (WIDTH > FIELD_W) ? WIDTH : FIELD_W;
    localparam logic [VW-1:0] Limit = VW'((65'd1 << WIDTH) - 65'd1);

    logic [VW-1:0] r_m, r_r0, r_r1, r_s0, r_s1, r_x, r_c, r_mp, r_t, r_lm, r_rr;
    logic          r_start, r_failed, r_ovf;
    // Reduced residue of the current item; r_r0 is busy with the gcd
    logic [VW-1:0] r_r;

    logic               r_out_valid;
    logic [FIELD_W-1:0] r_sol, r_cmod;
    logic               r_cons, r_oflow;

    logic          w_start;
    t_eng_op       w_op;
    logic [VW-1:0] w_a, w_b, w_em;
    logic          w_done;
    logic [VW-1:0] w_quo, w_rem;
    logic [VW-1:0] w_in_mod, w_in_res, w_diff, w_st, w_sol;
    logic [VW:0]   w_dsum, w_ssum;

    crt_engine #(.VW(VW)) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_op    (w_op),
        .i_a     (w_a),
        .i_b     (w_b),
        .i_m     (w_em),
        .o_done  (w_done),
        .o_quo   (w_quo),
        .o_rem   (w_rem)
    );

    always_comb begin
        w_in_res = VW'(i_in.residue);
        w_in_mod = (i_in.modulus == '0) ? VW'(1) : VW'(i_in.modulus);
        // (r + m - (rr mod m)) mod m, all terms below m
        w_dsum = {1'b0, r_r} + {1'b0, r_m} - {1'b0, w_rem};
        w_diff = (w_dsum >= {1'b0, r_m}) ? VW'(w_dsum - {1'b0, r_m}) : VW'(w_dsum);
        w_ssum = {1'b0, r_s0} + {1'b0, r_m} - {1'b0, w_rem};
        w_st   = (w_ssum >= {1'b0, r_m}) ? VW'(w_ssum - {1'b0, r_m}) : VW'(w_ssum);
        w_sol  = (r_rr == '0) ? r_lm : r_rr;
    end

    always_comb begin
        w_start = 1'b1;
        w_op    = E_DIV;
        w_a     = '0;
        w_b     = '0;
        w_em    = VW'(1);
        case (i_cmd)
            C_ACCEPT: begin
                w_a  = w_in_res;
                w_em = w_in_mod;
            end
            C_GCD_DIV: begin
                w_a  = r_r0;
                w_em = r_r1;
            end
            C_GQ_DONE: begin
                w_a  = w_quo;
                w_em = r_m;
            end
            C_GQM_DONE: begin
                w_op = E_MODMUL;
                w_a  = w_rem;
                w_b  = r_s1;
                w_em = r_m;
            end
            C_RRM_START: begin
                w_a  = r_rr;
                w_em = r_m;
            end
            C_RRM_DONE: begin
                w_a  = w_diff;
                w_em = r_r0;
            end
            C_DIFF_OK: begin
                w_a  = r_m;
                w_em = r_r0;
            end
            C_MP_DONE: begin
                w_a  = r_s0;
                w_em = w_quo;
            end
            C_SMP_DONE: begin
                w_op = E_MODMUL;
                w_a  = w_rem;
                w_b  = r_c;
                w_em = r_mp;
            end
            C_T_DONE: begin
                w_a  = Limit;
                w_em = r_mp;
            end
            C_LIM_OK: begin
                w_op = E_MUL;
                w_a  = r_t;
                w_b  = r_lm;
            end
            C_TL_DONE: begin
                w_op = E_MUL;
                w_a  = r_lm;
                w_b  = r_mp;
            end
            default: begin
                w_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lm     <= VW'(1);
            r_rr     <= '0;
            r_failed <= 1'b0;
            r_ovf    <= 1'b0;
        end else begin
            case (i_cmd)
                C_START_SET: begin
                    r_failed <= 1'b0;
                    if (r_m > Limit) begin
                        r_ovf <= 1'b1;
                        r_lm  <= VW'(1);
                        r_rr  <= '0;
                    end else begin
                        r_ovf <= 1'b0;
                        r_lm  <= r_m;
                        r_rr  <= w_rem;
                    end
                end
                C_DIFF_FAIL: r_failed <= 1'b1;
                C_LIM_OVF:   r_ovf    <= 1'b1;
                C_LM_DONE: begin
                    r_lm <= w_rem;
                    r_rr <= r_x;
                end
                default: begin
                    r_lm <= r_lm;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            C_ACCEPT: begin
                r_m     <= w_in_mod;
                r_start <= i_in.start_req;
            end
            C_RED_DONE: begin
                r_r  <= w_rem;
                r_r0 <= r_lm;
                r_r1 <= r_m;
                r_s0 <= (r_m == VW'(1)) ? '0 : VW'(1);
                r_s1 <= '0;
            end
            C_GQ_DONE: r_x <= w_rem;
            C_GMM_DONE: begin
                r_r0 <= r_r1;
                r_r1 <= r_x;
                r_s0 <= r_s1;
                r_s1 <= w_st;
            end
            C_DIFF_OK:  r_c  <= w_quo;
            C_MP_DONE:  r_mp <= w_quo;
            C_T_DONE:   r_t  <= w_rem;
            C_TL_DONE:  r_x  <= r_rr + w_rem;
            default: begin
                r_m <= r_m;
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd == C_OUT) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == C_OUT) begin
            r_sol   <= (r_failed || r_ovf) ? '0 : w_sol[FIELD_W-1:0];
            r_cmod  <= r_lm[FIELD_W-1:0];
            r_cons  <= !r_failed;
            r_oflow <= r_ovf;
        end
    end

    assign o_status.eng_done   = w_done;
    assign o_status.start_flag = r_start;
    assign o_status.stop       = r_failed || r_ovf;
    assign o_status.r1_zero    = (r_r1 == '0);
    assign o_status.rem_nz     = (w_rem != '0);
    assign o_status.lim_over   = (r_lm > w_quo);
    assign o_status.out_busy   = r_out_valid && !o_out.ready;

    assign i_in.ready             = (i_cmd == C_ACCEPT);
    assign o_out.valid            = r_out_valid;
    assign o_out.solution         = r_sol;
    assign o_out.combined_modulus = r_cmod;
    assign o_out.consistent       = r_cons;
    assign o_out.overflow         = r_oflow;

endmodule

/* hdl/crt_ctrl.sv */
`timescale 1ns / 1ps
// ============================================================================
// crt_ctrl
// Controller: sequences the merge steps and issues datapath commands.
// ============================================================================
module crt_ctrl
    import crt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = C_NOP;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd   = C_ACCEPT;
                    n_state = S_RED;
                end
            end
            S_RED: begin
                if (i_status.eng_done) begin
                    if (i_status.start_flag) begin
                        o_cmd   = C_START_SET;
                        n_state = S_OUT;
                    end else if (i_status.stop) begin
                        n_state = S_OUT;
                    end else begin
                        o_cmd   = C_RED_DONE;
                        n_state = S_GTEST;
                    end
                end
            end
            S_GTEST: begin
                if (i_status.r1_zero) begin
                    o_cmd   = C_RRM_START;
                    n_state = S_RRM;
                end else begin
                    o_cmd   = C_GCD_DIV;
                    n_state = S_GQ;
                end
            end
            S_GQ: begin
                if (i_status.eng_done) begin
                    o_cmd   = C_GQ_DONE;
                    n_state = S_GQM;
                end
            end
            S_GQM: begin
                if (i_status.eng_done) begin
                    o_cmd   = C_GQM_DONE;
                    n_state = S_GMM;
                end
            end
            S_GMM: begin
                if (i_status.eng_done) begin
                    o_cmd   = C_GMM_DONE;
                    n_state = S_GTEST;
                end
            end
            S_RRM: begin
                if (i_status.eng_done) begin
                    o_cmd   = C_RRM_DONE;
                    n_state = S_DIFF;
                end
            end
            S_DIFF: begin
                if (i_status.eng_done) begin
                    if (i_status.rem_nz) begin
                        o_cmd   = C_DIFF_FAIL;
                        n_state = S_OUT;
                    end else begin
                        o_cmd   = C_DIFF_OK;
                        n_state = S_MP;
                    end
                end
            end
            S_MP: begin
                if (i_status.eng_done) begin
                    o_cmd   = C_MP_DONE;
                    n_state = S_SMP;
                end
            end
            S_SMP: begin
                if (i_status.eng_done) begin
                    o_cmd   = C_SMP_DONE;
                    n_state = S_T;
                end
            end
            S_T: begin
                if (i_status.eng_done) begin
                    o_cmd   = C_T_DONE;
                    n_state = S_LIM;
                end
            end
            S_LIM: begin
                if (i_status.eng_done) begin
                    if (i_status.lim_over) begin
                        o_cmd   = C_LIM_OVF;
                        n_state = S_OUT;
                    end else begin
                        o_cmd   = C_LIM_OK;
                        n_state = S_TL;
                    end
                end
            end
            S_TL: begin
                if (i_status.eng_done) begin
                    o_cmd   = C_TL_DONE;
                    n_state = S_LM;
                end
            end
            S_LM: begin
                if (i_status.eng_done) begin
                    o_cmd   = C_LM_DONE;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                // hold until the output register is free
                if (!i_status.out_busy) begin
                    o_cmd   = C_OUT;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* hdl/crt_congruence_merge.sv */
`timescale 1ns / 1ps
// ============================================================================
// crt_congruence_merge
// Generalized CRT merge of congruences with non-coprime moduli.
// ============================================================================
//  channel | dir | fields
//  i_in    | in  | residue[47:0], modulus[47:0], start_req
//  o_out   | out | solution[47:0], combined_modulus[47:0], consistent, overflow
//
//  One item at a time; all arithmetic runs through one bit-serial unit
//  of width VW = max(WIDTH,48). A start or ignored item goes from accept
//  through reduction and output back to idle; a merge adds the extended
//  Euclid loop and the combine steps before its output.
//  Reset is synchronous, active low; it restores x = 0 (mod 1).
//  The next item is taken while a result beat waits on o_out; a stalled
//  output holds the controller only when the following result is ready.
// ============================================================================
module crt_congruence_merge
    import crt_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    crt_in_if.sink    i_in,
    crt_out_if.source o_out
);

    t_cmd    w_cmd;
    t_status w_status;

    crt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    crt_dpath #(.WIDTH(WIDTH)) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .i_in     (i_in),
        .o_out    (o_out)
    );

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !i_in.ready)
        else $error("second beat accepted while busy");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.consistent |-> o_out.solution == '0)
        else $error("inconsistent result with nonzero solution");

    a_ovf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.overflow |-> o_out.solution == '0)
        else $error("overflowed result with nonzero solution");

endmodule
